// File: rtl/kts_pkg.sv
// ----------------------------------------------------------------------------
// kts_pkg
// shared types, register indexes and the decay table of the touch scroller
// ----------------------------------------------------------------------------
package kts_pkg;

  localparam int POS_W   = 17;  // scroll offset, two's complement
  localparam int SUM_W   = 19;  // offset plus a movement, before clamping
  localparam int MAX_W   = 16;
  localparam int REG_W   = 12;
  localparam int CFG_W   = 16;
  localparam int INDEX_W = 3;
  localparam int STEP_W  = 6;
  localparam int TABLE_LEN = 64;

  localparam logic [STEP_W-1:0] STEP_LAST = 6'd63;

  // register indexes
  localparam logic [INDEX_W-1:0] REG_AXIS_ENABLE    = 3'd0;
  localparam logic [INDEX_W-1:0] REG_MAX_OFFSET_X   = 3'd1;
  localparam logic [INDEX_W-1:0] REG_MAX_OFFSET_Y   = 3'd2;
  localparam logic [INDEX_W-1:0] REG_DRAG_THRESHOLD = 3'd3;
  localparam logic [INDEX_W-1:0] REG_REGION_LEFT    = 3'd4;
  localparam logic [INDEX_W-1:0] REG_REGION_TOP     = 3'd5;
  localparam logic [INDEX_W-1:0] REG_REGION_WIDTH   = 3'd6;
  localparam logic [INDEX_W-1:0] REG_REGION_HEIGHT  = 3'd7;

  localparam logic [1:0]       AXIS_ENABLE_RESET    = 2'd2;
  localparam logic [REG_W-1:0] DRAG_THRESHOLD_RESET = 12'd10;

  // round(65536 * exp(-0.15 k)), Q1.16
  localparam logic [16:0] DECAY_Q16 [TABLE_LEN] = '{
    17'd65536, 17'd56407, 17'd48550, 17'd41787, 17'd35967, 17'd30957, 17'd26645, 17'd22934,
    17'd19739, 17'd16990, 17'd14623, 17'd12586, 17'd10833, 17'd9324,  17'd8025,  17'd6907,
    17'd5945,  17'd5117,  17'd4404,  17'd3791,  17'd3263,  17'd2808,  17'd2417,  17'd2080,
    17'd1791,  17'd1541,  17'd1327,  17'd1142,  17'd983,   17'd846,   17'd728,   17'd627,
    17'd539,   17'd464,   17'd400,   17'd344,   17'd296,   17'd255,   17'd219,   17'd189,
    17'd162,   17'd140,   17'd120,   17'd104,   17'd89,    17'd77,    17'd66,    17'd57,
    17'd49,    17'd42,    17'd36,    17'd31,    17'd27,    17'd23,    17'd20,    17'd17,
    17'd15,    17'd13,    17'd11,    17'd9,     17'd8,     17'd7,     17'd6,     17'd5
  };

  // per-axis control for one sample
  typedef struct packed {
    logic drag_en;   // finger held in region, anchor known, axis enabled
    logic lift;      // block active, no finger in region
  } axis_ctl_t;

  // hold an offset in -max..0
  function automatic logic signed [POS_W-1:0] clamp_pos(
    input logic signed [SUM_W-1:0] sum,
    input logic [MAX_W-1:0]        max_offset
  );
    logic signed [SUM_W-1:0] low;
    logic signed [POS_W-1:0] res;
    low = -$signed({{(SUM_W-MAX_W){1'b0}}, max_offset});
    if (sum > 0) begin
      res = '0;
    end else if (sum < low) begin
      res = low[POS_W-1:0];
    end else begin
      res = sum[POS_W-1:0];
    end
    return res;
  endfunction

endpackage

// File: rtl/kts_if.sv
// ----------------------------------------------------------------------------
// kts_if
// valid/ready channels for touch samples and scroll offsets
// ----------------------------------------------------------------------------
interface kts_touch_if #(
  parameter int COORD_BITS = 12
);
  logic                  valid;
  logic                  ready;
  logic                  touch_present;
  logic [COORD_BITS-1:0] touch_x;
  logic [COORD_BITS-1:0] touch_y;

  modport source (output valid, touch_present, touch_x, touch_y, input ready);
  modport sink   (input valid, touch_present, touch_x, touch_y, output ready);
endinterface

interface kts_offset_if;
  logic               valid;
  logic               ready;
  logic signed [16:0] offset_x;
  logic signed [16:0] offset_y;

  modport source (output valid, offset_x, offset_y, input ready);
  modport sink   (input valid, offset_x, offset_y, output ready);
endinterface

// File: rtl/kts_region.sv
// ----------------------------------------------------------------------------
// kts_region
// hit test of a touch sample against the sensitive rectangle
// ----------------------------------------------------------------------------
module kts_region #(
  parameter int COORD_BITS = 12
) (
  input  logic                      touch_present,
  input  logic [COORD_BITS-1:0]     touch_x,
  input  logic [COORD_BITS-1:0]     touch_y,
  input  logic [kts_pkg::REG_W-1:0] region_left,
  input  logic [kts_pkg::REG_W-1:0] region_top,
  input  logic [kts_pkg::REG_W-1:0] region_width,
  input  logic [kts_pkg::REG_W-1:0] region_height,
  output logic                      hit
);
  import kts_pkg::*;

  localparam int HW = (COORD_BITS > REG_W + 1) ? COORD_BITS : REG_W + 1;

  logic [REG_W:0] right;
  logic [REG_W:0] bottom;
  logic           in_x;
  logic           in_y;

  // edges summed without wrap
  assign right  = {1'b0, region_left} + {1'b0, region_width};
  assign bottom = {1'b0, region_top} + {1'b0, region_height};

  assign in_x = (HW'(touch_x) >= HW'(region_left)) && (HW'(touch_x) < HW'(right));
  assign in_y = (HW'(touch_y) >= HW'(region_top)) && (HW'(touch_y) < HW'(bottom));
  assign hit  = touch_present && in_x && in_y;

endmodule

// File: rtl/kts_decay.sv
// ----------------------------------------------------------------------------
// kts_decay
// vertical coast value: speed times exp(-0.15 k), truncated toward zero
// ----------------------------------------------------------------------------
module kts_decay #(
  parameter int COORD_BITS    = 12,
  parameter int DECAY_STEPS   = 64,
  parameter int FRACTION_BITS = 16
) (
  input  logic signed [COORD_BITS:0]     speed,
  input  logic [kts_pkg::STEP_W-1:0]     step,
  output logic signed [COORD_BITS+1:0]   value
);
  import kts_pkg::*;

  localparam int FW = FRACTION_BITS + 1;
  localparam int MW = COORD_BITS + 1;
  localparam int PW = MW + FW;

  logic [16:0]     entry;
  logic [FW-1:0]   factor;
  logic [MW-1:0]   mag;
  logic [PW-1:0]   product;
  logic [MW-1:0]   value_mag;

  always_comb begin
    if ({3'b000, step} < 9'(DECAY_STEPS)) begin
      entry = DECAY_Q16[step];
    end else begin
      entry = '0;
    end
  end

  // rescale the Q1.16 entry to the working fraction
  if (FRACTION_BITS >= 16) begin : g_up
    localparam int SH = FRACTION_BITS - 16;
    assign factor = FW'(entry) << SH;
  end else begin : g_down
    localparam int SH = 16 - FRACTION_BITS;
    assign factor = FW'(entry >> SH);
  end

  assign mag       = speed[COORD_BITS] ? MW'(-speed) : MW'(speed);
  assign product   = PW'(mag) * PW'(factor);
  assign value_mag = product[FRACTION_BITS +: MW];

  always_comb begin
    if (speed[COORD_BITS]) begin
      value = -$signed({1'b0, value_mag});
    end else begin
      value = $signed({1'b0, value_mag});
    end
  end

endmodule

// File: rtl/kts_axis.sv
// ----------------------------------------------------------------------------
// kts_axis
// next offset, drag delta and coast speed of one scroll axis
// ----------------------------------------------------------------------------
module kts_axis #(
  parameter int COORD_BITS = 12
) (
  input  kts_pkg::axis_ctl_t                  ctl,
  input  logic [COORD_BITS-1:0]               now,
  input  logic [COORD_BITS-1:0]               prev,
  input  logic signed [kts_pkg::POS_W-1:0]    pos,
  input  logic signed [COORD_BITS:0]          delta,
  input  logic signed [COORD_BITS:0]          speed,
  input  logic signed [COORD_BITS+1:0]        coast_value,
  input  logic [kts_pkg::MAX_W-1:0]           max_offset,
  input  logic [kts_pkg::REG_W-1:0]           drag_threshold,
  output logic signed [kts_pkg::POS_W-1:0]    pos_next,
  output logic signed [COORD_BITS:0]          delta_next,
  output logic signed [COORD_BITS:0]          speed_next,
  output logic                                coasting,
  output logic                                launching
);
  import kts_pkg::*;

  localparam int DW = COORD_BITS + 1;
  localparam int CW = (DW > REG_W) ? DW : REG_W;

  logic signed [DW-1:0]    d;
  logic [DW-1:0]           d_mag;
  logic                    moving;
  logic signed [SUM_W-1:0] pos_ext;
  logic signed [SUM_W-1:0] sum;

  assign d       = $signed({1'b0, now}) - $signed({1'b0, prev});
  assign d_mag   = d[DW-1] ? DW'(-d) : DW'(d);
  assign moving  = (delta != 0) || (CW'(d_mag) > CW'(drag_threshold));
  assign pos_ext = {{(SUM_W-POS_W){pos[POS_W-1]}}, pos};

  assign coasting  = ctl.lift && (speed != 0);
  assign launching = ctl.lift && (speed == 0);

  always_comb begin
    pos_next   = pos;
    delta_next = delta;
    speed_next = speed;
    sum        = pos_ext;
    if (ctl.drag_en) begin
      if (moving) begin
        sum        = pos_ext + {{(SUM_W-DW){d[DW-1]}}, d};
        delta_next = d;
        speed_next = '0;
      end
      pos_next = clamp_pos(sum, max_offset);
    end else if (ctl.lift) begin
      if (speed != 0) begin
        sum = pos_ext + {{(SUM_W-DW-1){coast_value[DW]}}, coast_value};
        if (coast_value == 0) begin
          speed_next = '0;
        end
      end else begin
        // last drag movement turns into inertia
        speed_next = delta;
        delta_next = '0;
      end
      pos_next = clamp_pos(sum, max_offset);
    end
  end

endmodule

// File: rtl/kinetic_touch_scroller.sv
// ----------------------------------------------------------------------------
// kinetic_touch_scroller
// touch-driven scroll offsets with drag threshold and coasting inertia
// ----------------------------------------------------------------------------
// path: a sample accepted on the touch channel passes the input register, then
//   the result register, before its offsets appear on the result channel
// throughput: one sample per cycle unless the result channel stalls; the
//   update is combinational between the input and state/result registers
// reset: rst (synchronous) clears all tracking state and both offsets, and
//   loads the register defaults (vertical scrolling on, threshold 10)
// ----------------------------------------------------------------------------
module kinetic_touch_scroller #(
  parameter int COORD_BITS    = 12,
  parameter int DECAY_STEPS   = 64,
  parameter int FRACTION_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [kts_pkg::INDEX_W-1:0] cfg_index,
  input  logic [kts_pkg::CFG_W-1:0]   cfg_data,
  kts_touch_if.sink                   touch,
  kts_offset_if.source                scroll
);
  import kts_pkg::*;

  localparam int DW = COORD_BITS + 1;

  // configuration registers
  logic [1:0]       axis_enable;
  logic [MAX_W-1:0] max_offset_x;
  logic [MAX_W-1:0] max_offset_y;
  logic [REG_W-1:0] drag_threshold;
  logic [REG_W-1:0] region_left;
  logic [REG_W-1:0] region_top;
  logic [REG_W-1:0] region_width;
  logic [REG_W-1:0] region_height;

  // input register
  logic                  in_valid;
  logic                  in_present;
  logic [COORD_BITS-1:0] in_x;
  logic [COORD_BITS-1:0] in_y;

  // tracking state
  logic                    anchor_valid;
  logic [COORD_BITS-1:0]   anchor_x;
  logic [COORD_BITS-1:0]   anchor_y;
  logic signed [POS_W-1:0] scroll_pos_x;
  logic signed [POS_W-1:0] scroll_pos_y;
  logic signed [DW-1:0]    drag_delta_x;
  logic signed [DW-1:0]    drag_delta_y;
  logic signed [DW-1:0]    coast_speed_x;
  logic signed [DW-1:0]    coast_speed_y;
  logic                    coast_step_x;
  logic [STEP_W-1:0]       coast_step_y;

  // result register
  logic                    out_valid;
  logic signed [POS_W-1:0] out_x;
  logic signed [POS_W-1:0] out_y;

  // update logic
  logic                    advance;
  logic                    fire;
  logic                    active;
  logic                    hit;
  axis_ctl_t               ctl_x;
  axis_ctl_t               ctl_y;
  logic signed [DW:0]      coast_value_x;
  logic signed [DW:0]      coast_value_y;
  logic signed [POS_W-1:0] scroll_pos_x_next;
  logic signed [POS_W-1:0] scroll_pos_y_next;
  logic signed [DW-1:0]    drag_delta_x_next;
  logic signed [DW-1:0]    drag_delta_y_next;
  logic signed [DW-1:0]    coast_speed_x_next;
  logic signed [DW-1:0]    coast_speed_y_next;
  logic                    coasting_x;
  logic                    coasting_y;
  logic                    launching_x;
  logic                    launching_y;

  // ---------------------------------------------------------------- handshake
  // the result register frees when empty or taken; the input register
  // moves into it in the same cycle, so a word enters every cycle unless the result channel stalls
  assign advance     = !out_valid || scroll.ready;
  assign fire        = in_valid && advance;
  assign touch.ready = !in_valid || advance;

  assign scroll.valid    = out_valid;
  assign scroll.offset_x = out_x;
  assign scroll.offset_y = out_y;

  // ------------------------------------------------------------ config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      axis_enable    <= AXIS_ENABLE_RESET;
      max_offset_x   <= '0;
      max_offset_y   <= '0;
      drag_threshold <= DRAG_THRESHOLD_RESET;
      region_left    <= '0;
      region_top     <= '0;
      region_width   <= '0;
      region_height  <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_AXIS_ENABLE:    axis_enable    <= cfg_data[1:0];
        REG_MAX_OFFSET_X:   max_offset_x   <= cfg_data[MAX_W-1:0];
        REG_MAX_OFFSET_Y:   max_offset_y   <= cfg_data[MAX_W-1:0];
        REG_DRAG_THRESHOLD: drag_threshold <= cfg_data[REG_W-1:0];
        REG_REGION_LEFT:    region_left    <= cfg_data[REG_W-1:0];
        REG_REGION_TOP:     region_top     <= cfg_data[REG_W-1:0];
        REG_REGION_WIDTH:   region_width   <= cfg_data[REG_W-1:0];
        REG_REGION_HEIGHT:  region_height  <= cfg_data[REG_W-1:0];
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------ input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (touch.ready) begin
      in_valid <= touch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (touch.valid && touch.ready) begin
      in_present <= touch.touch_present;
      in_x       <= touch.touch_x;
      in_y       <= touch.touch_y;
    end
  end

  // ------------------------------------------------------------- sample decode
  kts_region #(
    .COORD_BITS (COORD_BITS)
  ) u_region (
    .touch_present (in_present),
    .touch_x       (in_x),
    .touch_y       (in_y),
    .region_left   (region_left),
    .region_top    (region_top),
    .region_width  (region_width),
    .region_height (region_height),
    .hit           (hit)
  );

  // all-zero enable freezes everything; a release acts on both axes
  assign active        = axis_enable != 2'b00;
  assign ctl_x.drag_en = active && hit && anchor_valid && axis_enable[0];
  assign ctl_x.lift    = active && !hit;
  assign ctl_y.drag_en = active && hit && anchor_valid && axis_enable[1];
  assign ctl_y.lift    = active && !hit;

  // ------------------------------------------------------------- coast values
  // horizontal inertia is applied to a single glide sample only
  assign coast_value_x = coast_step_x ? '0 : {coast_speed_x[DW-1], coast_speed_x};

  // vertical inertia decays along the exponential table
  kts_decay #(
    .COORD_BITS    (COORD_BITS),
    .DECAY_STEPS   (DECAY_STEPS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_decay (
    .speed (coast_speed_y),
    .step  (coast_step_y),
    .value (coast_value_y)
  );

  // -------------------------------------------------------------- axis update
  kts_axis #(
    .COORD_BITS (COORD_BITS)
  ) u_axis_x (
    .ctl            (ctl_x),
    .now            (in_x),
    .prev           (anchor_x),
    .pos            (scroll_pos_x),
    .delta          (drag_delta_x),
    .speed          (coast_speed_x),
    .coast_value    (coast_value_x),
    .max_offset     (max_offset_x),
    .drag_threshold (drag_threshold),
    .pos_next       (scroll_pos_x_next),
    .delta_next     (drag_delta_x_next),
    .speed_next     (coast_speed_x_next),
    .coasting       (coasting_x),
    .launching      (launching_x)
  );

  kts_axis #(
    .COORD_BITS (COORD_BITS)
  ) u_axis_y (
    .ctl            (ctl_y),
    .now            (in_y),
    .prev           (anchor_y),
    .pos            (scroll_pos_y),
    .delta          (drag_delta_y),
    .speed          (coast_speed_y),
    .coast_value    (coast_value_y),
    .max_offset     (max_offset_y),
    .drag_threshold (drag_threshold),
    .pos_next       (scroll_pos_y_next),
    .delta_next     (drag_delta_y_next),
    .speed_next     (coast_speed_y_next),
    .coasting       (coasting_y),
    .launching      (launching_y)
  );

  // ---------------------------------------------------------- state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      anchor_valid  <= 1'b0;
      anchor_x      <= '0;
      anchor_y      <= '0;
      scroll_pos_x  <= '0;
      scroll_pos_y  <= '0;
      drag_delta_x  <= '0;
      drag_delta_y  <= '0;
      coast_speed_x <= '0;
      coast_speed_y <= '0;
      coast_step_x  <= 1'b0;
      coast_step_y  <= '0;
    end else if (fire) begin
      scroll_pos_x  <= scroll_pos_x_next;
      scroll_pos_y  <= scroll_pos_y_next;
      drag_delta_x  <= drag_delta_x_next;
      drag_delta_y  <= drag_delta_y_next;
      coast_speed_x <= coast_speed_x_next;
      coast_speed_y <= coast_speed_y_next;
      if (active) begin
        // finger in region becomes the anchor for the next movement
        anchor_valid <= hit;
        if (hit) begin
          anchor_x <= in_x;
          anchor_y <= in_y;
        end
      end
      if (coasting_x) begin
        coast_step_x <= 1'b1;
      end else if (launching_x) begin
        coast_step_x <= 1'b0;
      end
      if (coasting_y) begin
        if (coast_step_y != STEP_LAST) begin
          coast_step_y <= coast_step_y + 1'b1;
        end
      end else if (launching_y) begin
        coast_step_y <= '0;
      end
    end
  end

  // --------------------------------------------------------- result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_x <= scroll_pos_x_next;
      out_y <= scroll_pos_y_next;
    end
  end

endmodule

// File: tb/sv/kts_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kts_checker
// watches the register port and both channels, tracks the scroller state per
// touch word and compares every offset word against the tracked offsets
// ----------------------------------------------------------------------------
module kts_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [kts_pkg::INDEX_W-1:0] cfg_index,
  input  logic [kts_pkg::CFG_W-1:0]   cfg_data,
  kts_touch_if                        touch,
  kts_offset_if                       scroll,
  output int                          mismatches,
  output int                          outstanding
);
  import kts_pkg::*;

  localparam int DECAY_STEPS   = 64;
  localparam int FRACTION_BITS = 16;

  typedef struct packed {
    logic signed [POS_W-1:0] off_x;
    logic signed [POS_W-1:0] off_y;
  } offset_pair_t;

  // register copies
  logic [1:0] axis_en;
  int max_x, max_y, thresh;
  int reg_left, reg_top, reg_width, reg_height;

  // tracked scroller state
  bit held;
  int held_x, held_y;
  int pos_x, pos_y;
  int move_x, move_y;
  int glide_x, glide_y;
  bit glide_x_done;
  int glide_y_idx;

  offset_pair_t offset_queue[$];
  int fail_total = 0;

  function automatic int pin(input int p, input int lim);
    if (p > 0) return 0;
    if (p < -lim) return -lim;
    return p;
  endfunction

  function automatic int magnitude(input int v);
    return (v < 0) ? -v : v;
  endfunction

  // speed * exp(-0.15 k), truncated toward zero
  function automatic int decayed(input int speed, input int k);
    longint factor;
    int v;
    if (k >= TABLE_LEN || k >= DECAY_STEPS) begin
      factor = 0;
    end else begin
      factor = longint'(DECAY_Q16[k]) << (FRACTION_BITS - 16);
    end
    v = int'((longint'(magnitude(speed)) * factor) >> FRACTION_BITS);
    return (speed < 0) ? -v : v;
  endfunction

  task automatic drag_track(input int now, input int prev, inout int pos, inout int move,
                            inout int glide, input int lim);
    int d;
    d = now - prev;
    if (move != 0 || magnitude(d) > thresh) begin
      pos += d;
      move = d;
      glide = 0;
    end
    pos = pin(pos, lim);
  endtask

  task automatic scroll_step(input logic present, input int tx, input int ty,
                             output offset_pair_t res);
    bit hit;
    int v;
    if (axis_en != 2'b00) begin
      hit = present && tx >= reg_left && tx < reg_left + reg_width &&
            ty >= reg_top && ty < reg_top + reg_height;
      if (hit) begin
        if (held) begin
          if (axis_en[0]) drag_track(tx, held_x, pos_x, move_x, glide_x, max_x);
          if (axis_en[1]) drag_track(ty, held_y, pos_y, move_y, glide_y, max_y);
        end
        held = 1'b1;
        held_x = tx;
        held_y = ty;
      end else begin
        // release acts on both axes whatever the enables say
        held = 1'b0;
        if (glide_x != 0) begin
          v = glide_x_done ? 0 : glide_x;
          pos_x += v;
          glide_x_done = 1'b1;
          if (v == 0) glide_x = 0;
        end else begin
          glide_x = move_x;
          move_x = 0;
          glide_x_done = 1'b0;
        end
        if (glide_y != 0) begin
          v = decayed(glide_y, glide_y_idx);
          pos_y += v;
          if (glide_y_idx < int'(STEP_LAST)) glide_y_idx++;
          if (v == 0) glide_y = 0;
        end else begin
          glide_y = move_y;
          move_y = 0;
          glide_y_idx = 0;
        end
        pos_x = pin(pos_x, max_x);
        pos_y = pin(pos_y, max_y);
      end
    end
    res.off_x = pos_x[POS_W-1:0];
    res.off_y = pos_y[POS_W-1:0];
  endtask

  task automatic report(input string what, input int got, input int want);
    if (fail_total < 100) begin
      $display("mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
    end
    fail_total++;
  endtask

  always @(posedge clk) begin
    offset_pair_t seen;
    offset_pair_t want;
    offset_pair_t fresh;
    if (rst) begin
      axis_en      = AXIS_ENABLE_RESET;
      max_x        = 0;
      max_y        = 0;
      thresh       = int'(DRAG_THRESHOLD_RESET);
      reg_left     = 0;
      reg_top      = 0;
      reg_width    = 0;
      reg_height   = 0;
      held         = 1'b0;
      held_x       = 0;
      held_y       = 0;
      pos_x        = 0;
      pos_y        = 0;
      move_x       = 0;
      move_y       = 0;
      glide_x      = 0;
      glide_y      = 0;
      glide_x_done = 1'b0;
      glide_y_idx  = 0;
      offset_queue.delete();
    end else begin
      if (scroll.valid && scroll.ready) begin
        seen.off_x = scroll.offset_x;
        seen.off_y = scroll.offset_y;
        if (offset_queue.size() == 0) begin
          report("offset word with no touch word behind it", int'($signed(seen.off_x)), 0);
        end else begin
          want = offset_queue.pop_front();
          if (seen.off_x !== want.off_x) begin
            report("offset_x", int'($signed(seen.off_x)), int'($signed(want.off_x)));
          end
          if (seen.off_y !== want.off_y) begin
            report("offset_y", int'($signed(seen.off_y)), int'($signed(want.off_y)));
          end
        end
      end
      if (touch.valid && touch.ready) begin
        scroll_step(touch.touch_present, int'(touch.touch_x), int'(touch.touch_y), fresh);
        offset_queue.push_back(fresh);
      end
      if (cfg_write) begin
        case (cfg_index)
          REG_AXIS_ENABLE:    axis_en    = cfg_data[1:0];
          REG_MAX_OFFSET_X:   max_x      = int'(cfg_data[MAX_W-1:0]);
          REG_MAX_OFFSET_Y:   max_y      = int'(cfg_data[MAX_W-1:0]);
          REG_DRAG_THRESHOLD: thresh     = int'(cfg_data[REG_W-1:0]);
          REG_REGION_LEFT:    reg_left   = int'(cfg_data[REG_W-1:0]);
          REG_REGION_TOP:     reg_top    = int'(cfg_data[REG_W-1:0]);
          REG_REGION_WIDTH:   reg_width  = int'(cfg_data[REG_W-1:0]);
          REG_REGION_HEIGHT:  reg_height = int'(cfg_data[REG_W-1:0]);
          default: ;
        endcase
      end
    end
    mismatches  <= fail_total;
    outstanding <= offset_queue.size();
  end

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// stimulus and verdict for the kinetic touch scroller: directed touch words
// around the threshold, glide and region edges, then random gesture runs
// over a series of register setups, with random stalls on both channels
// ----------------------------------------------------------------------------
module tb;
  import kts_pkg::*;

  localparam int CLK_PERIOD    = 10;
  localparam int COORD_MAX     = 4095;
  localparam int PHASE_ITEMS   = 125;   // touch words per random setup
  localparam int FROZEN_ITEMS  = 30;    // frozen block only echoes offsets
  localparam int HOLD_CYCLES   = 200;   // long receiver hold-off
  localparam int IDLE_LIMIT    = 2000;  // cycles with no word moving on either side
  localparam int SETTLE_CYCLES = 6;     // settling margin after the last offset word is back

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                cfg_write;
  logic [INDEX_W-1:0]  cfg_index;
  logic [CFG_W-1:0]    cfg_data;

  int mismatch_total;
  int offsets_pending;

  // idling controls for the sender (calm_tx) and the receiver (calm_rx, hold_req)
  bit calm_tx;
  bit calm_rx;
  bit hold_req;

  // current region and threshold, so gestures land where they matter
  int win_left, win_top, win_width, win_height, cur_thresh;
  int samples_sent;

  kts_touch_if #(.COORD_BITS(12)) touch_if ();
  kts_offset_if                   scroll_if ();

  kinetic_touch_scroller u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .touch     (touch_if),
    .scroll    (scroll_if)
  );

  kts_checker u_chk (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .touch       (touch_if),
    .scroll      (scroll_if),
    .mismatches  (mismatch_total),
    .outstanding (offsets_pending)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap(input bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // coordinate inside the region along one axis; anywhere if the region is empty
  function automatic int pick_coord(input int lo, input int span);
    int hi;
    if (span == 0) return $urandom_range(0, COORD_MAX);
    hi = lo + span - 1;
    if (hi > COORD_MAX) hi = COORD_MAX;
    return $urandom_range(lo, hi);
  endfunction

  // next finger position along one axis, biased toward the negative end
  function automatic int step_coord(input int cur, input int lo, input int span,
                                    input int thr);
    int d;
    int lo_edge;
    int hi_edge;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: d = $urandom_range(0, 15);
      4, 5, 6:    d = thr + $urandom_range(0, 2) - 1;  // just under, at, just over
      7, 8:       d = $urandom_range(0, 600);
      default:    d = $urandom_range(0, COORD_MAX);
    endcase
    if (d < 0) d = 0;
    if ($urandom_range(0, 99) < 60) d = -d;
    if (span == 0) begin
      lo_edge = 0;
      hi_edge = COORD_MAX;
    end else begin
      lo_edge = lo;
      hi_edge = lo + span - 1;
      if (hi_edge > COORD_MAX) hi_edge = COORD_MAX;
    end
    cur += d;
    if (cur < lo_edge) cur = lo_edge;
    if (cur > hi_edge) cur = hi_edge;
    return cur;
  endfunction

  // offer one touch word, after a random gap, and wait until it is taken
  task automatic send_sample(input logic present, input int x, input int y);
    int gap;
    gap = pick_gap(calm_tx);
    @(negedge clk);
    if (gap > 0) begin
      // garbage on the payload while valid is low
      touch_if.valid         <= 1'b0;
      touch_if.touch_present <= 1'($urandom_range(0, 1));
      touch_if.touch_x       <= 12'($urandom);
      touch_if.touch_y       <= 12'($urandom);
      repeat (gap) @(negedge clk);
    end
    touch_if.valid         <= 1'b1;
    touch_if.touch_present <= present;
    touch_if.touch_x       <= x[11:0];
    touch_if.touch_y       <= y[11:0];
    @(posedge clk);
    while (!touch_if.ready) @(posedge clk);
    samples_sent++;
  endtask

  // stop offering and wait until every offset word is back and the block is quiet
  task automatic drain_all();
    @(negedge clk);
    touch_if.valid <= 1'b0;
    while (offsets_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [INDEX_W-1:0] idx, input int value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[CFG_W-1:0];
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // full register setup, only ever written with the block drained
  task automatic load_setup(input int ax, input int mx, input int my, input int thr,
                            input int l, input int t, input int w, input int h);
    drain_all();
    write_reg(REG_AXIS_ENABLE, ax);
    write_reg(REG_MAX_OFFSET_X, mx);
    write_reg(REG_MAX_OFFSET_Y, my);
    write_reg(REG_DRAG_THRESHOLD, thr);
    write_reg(REG_REGION_LEFT, l);
    write_reg(REG_REGION_TOP, t);
    write_reg(REG_REGION_WIDTH, w);
    write_reg(REG_REGION_HEIGHT, h);
    win_left   = l;
    win_top    = t;
    win_width  = w;
    win_height = h;
    cur_thresh = thr;
  endtask

  // one random gesture: mostly press, drag, lift and glide; some noise and
  // broken sequences that jump in and out of the region
  task automatic run_gesture();
    int x;
    int y;
    int coast;
    int kind;
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      repeat ($urandom_range(1, 6)) begin
        send_sample(1'($urandom_range(0, 1)), $urandom_range(0, COORD_MAX),
                    $urandom_range(0, COORD_MAX));
      end
    end else if (kind == 1) begin
      repeat ($urandom_range(2, 8)) begin
        if ($urandom_range(0, 1) == 1) begin
          send_sample(1'b1, pick_coord(win_left, win_width), pick_coord(win_top, win_height));
        end else begin
          send_sample(1'($urandom_range(0, 1)), $urandom_range(0, COORD_MAX),
                      $urandom_range(0, COORD_MAX));
        end
      end
    end else begin
      x = pick_coord(win_left, win_width);
      y = pick_coord(win_top, win_height);
      send_sample(1'b1, x, y);
      repeat ($urandom_range(1, 12)) begin
        x = step_coord(x, win_left, win_width, cur_thresh);
        y = step_coord(y, win_top, win_height, cur_thresh);
        send_sample(1'b1, x, y);
      end
      // lift: mostly no finger, now and then a finger that wanders off
      if ($urandom_range(0, 3) == 0) begin
        send_sample(1'b1, $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
      end else begin
        send_sample(1'b0, $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
      end
      // glide samples; long runs let the vertical decay die out
      coast = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 8);
      repeat (coast) begin
        // a finger resting briefly while the glide is still running
        if ($urandom_range(0, 15) == 0) begin
          send_sample(1'b1, pick_coord(win_left, win_width), pick_coord(win_top, win_height));
        end else begin
          send_sample(1'b0, $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
        end
      end
    end
  endtask

  // receiver: random stalls, plus one long hold-off when asked for
  initial begin
    int low_left;
    low_left = 0;
    scroll_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        low_left = HOLD_CYCLES;
      end
      if (low_left == 0 && !calm_rx && $urandom_range(0, 3) == 0) begin
        low_left = pick_gap(1'b0);
      end
      if (low_left > 0) begin
        scroll_if.ready <= 1'b0;
        low_left--;
      end else begin
        scroll_if.ready <= 1'b1;
      end
    end
  end

  // watchdog: ends the run when no word has moved for too long
  initial begin
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst || (touch_if.valid && touch_if.ready) || (scroll_if.valid && scroll_if.ready)) begin
        idle = 0;
      end else begin
        idle++;
      end
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // stimulus
  initial begin
    int phase;
    int target;
    int x;
    cfg_write              = 1'b0;
    cfg_index              = '0;
    cfg_data               = '0;
    touch_if.valid         = 1'b0;
    touch_if.touch_present = 1'b0;
    touch_if.touch_x       = '0;
    touch_if.touch_y       = '0;
    calm_tx                = 1'b0;
    calm_rx                = 1'b0;
    hold_req               = 1'b0;
    win_left               = 0;
    win_top                = 0;
    win_width              = 0;
    win_height             = 0;
    cur_thresh             = int'(DRAG_THRESHOLD_RESET);
    samples_sent           = 0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset setup: vertical only, empty region, so no word ever hits
    send_sample(1'b1, 0, 0);
    send_sample(1'b0, COORD_MAX, COORD_MAX);

    // both axes, full range, default threshold, region covering 0..4094
    load_setup(3, 65535, 65535, 10, 0, 0, COORD_MAX, COORD_MAX);
    send_sample(1'b1, 4094, 4094);       // press at the far corner
    send_sample(1'b1, 0, 0);             // full-range drag toward the floor
    send_sample(1'b1, 0, 0);             // drag goes on with no movement
    send_sample(1'b1, 10, 10);           // movement equal to the threshold
    send_sample(1'b1, 21, 21);           // one past the threshold starts a drag
    send_sample(1'b0, COORD_MAX, COORD_MAX);  // lift: glide speed from last move
    send_sample(1'b0, 0, 0);             // first glide tick on both axes
    send_sample(1'b1, COORD_MAX, 0);     // finger on the column just outside
    send_sample(1'b1, 200, 200);         // touch while the vertical glide runs
    send_sample(1'b1, 200, 200);         // held still, no drag
    send_sample(1'b0, 0, 0);             // glide picks up where it stopped

    // frozen block just echoes the offsets
    load_setup(0, 65535, 65535, 10, 0, 0, COORD_MAX, COORD_MAX);
    send_sample(1'b1, 5, 5);
    send_sample(1'b0, 0, 0);

    // max lowered to zero, threshold zero, region is the single last corner
    load_setup(3, 0, 0, 0, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
    send_sample(1'b1, COORD_MAX, COORD_MAX);
    send_sample(1'b1, COORD_MAX, COORD_MAX);  // first clamp under the new max
    send_sample(1'b1, 4094, COORD_MAX);
    send_sample(1'b0, 0, 0);

    // random part: a series of setups, extremes among them
    for (phase = 0; phase < 9; phase++) begin
      case (phase)
        0: load_setup(3, 65535, 65535, 10, 0, 0, COORD_MAX, COORD_MAX);
        1: load_setup(2, $urandom_range(0, 65535), $urandom_range(0, 65535), 0,
                      $urandom_range(0, 2000), $urandom_range(0, 2000),
                      $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
        2: load_setup(1, 0, 65535, COORD_MAX, 0, 0, COORD_MAX, COORD_MAX);
        3: load_setup(0, 65535, 65535, 0, 0, 0, COORD_MAX, COORD_MAX);
        4: load_setup(3, 100, 100, $urandom_range(0, 30),
                      $urandom_range(0, 2000), $urandom_range(0, 2000),
                      $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
        5: load_setup(3, 65535, 65535, 0, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
        6: load_setup(3, $urandom_range(0, 65535), $urandom_range(0, 65535),
                      $urandom_range(0, 40),
                      $urandom_range(0, 1500), $urandom_range(0, 1500),
                      $urandom_range(1000, COORD_MAX), $urandom_range(1000, COORD_MAX));
        7: load_setup($urandom_range(1, 3), $urandom_range(0, 65535),
                      $urandom_range(0, 65535), $urandom_range(0, COORD_MAX),
                      $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                      $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
        default: load_setup(3, $urandom_range(1000, 65535), $urandom_range(1000, 65535), 10,
                            0, 0, COORD_MAX, COORD_MAX);
      endcase

      // one setup runs with no idling on either side
      calm_tx = (phase == 2);
      calm_rx = (phase == 2);
      target = samples_sent + ((phase == 3) ? FROZEN_ITEMS : PHASE_ITEMS);

      if (phase == 0) begin
        // receiver holds off while a steady drag keeps coming: the block fills
        hold_req = 1'b1;
        calm_tx = 1'b1;
        x = 3000;
        repeat (12) begin
          send_sample(1'b1, x, x);
          x -= 200;
        end
        calm_tx = 1'b0;
      end

      while (samples_sent < target) run_gesture();
    end

    calm_tx = 1'b0;
    calm_rx = 1'b0;
    drain_all();
    repeat (10) @(negedge clk);

    if (mismatch_total == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
